// ===== rtl/core/cqdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cqdd_pkg
// Shared types and constants for the commit queue with durable drain: field
// widths, command codes, controller states and the slot unit interface.
// ----------------------------------------------------------------------------
package cqdd_pkg;

  localparam int CSN_W      = 63;
  localparam int TIME_W     = 64;
  localparam int WORD_W     = 64;
  localparam int SLOT_IDX_W = 6;
  localparam int CFG_W      = 7;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_REPORT,
    ST_SCAN,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_RESP
  } cqdd_state_t;

  // Requests from the controller to the slot unit
  typedef struct packed {
    logic                  rpt_en;
    logic [SLOT_IDX_W-1:0] rpt_slot;
    logic [WORD_W-1:0]     rpt_word;
    logic                  scan_start;
  } cqdd_slot_ctl_t;

  // Scan status back to the controller
  typedef struct packed {
    logic             done;
    logic [CSN_W-1:0] durable;
  } cqdd_slot_stat_t;

endpackage

// ===== rtl/core/cqdd_ram.sv =====
// ----------------------------------------------------------------------------
// cqdd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, valid in the cycle after the read is enabled. Contents are not reset.
// ----------------------------------------------------------------------------
module cqdd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cqdd_slot_unit.sv =====
// ----------------------------------------------------------------------------
// cqdd_slot_unit
// Thread durability slots: a slot RAM with per-slot valid bits (an unwritten
// slot reads as empty), report writes, and a scan that walks the active
// slots one per cycle to form the global durable number.
// ----------------------------------------------------------------------------
module cqdd_slot_unit #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cqdd_pkg::cqdd_slot_ctl_t     ctl,
  input  logic [cqdd_pkg::CFG_W-1:0]   active_slots,
  output cqdd_pkg::cqdd_slot_stat_t    stat
);

  localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);

  logic [MAX_SLOTS-1:0]             valid_r;
  logic                             busy_r;
  logic [SCNT_W-1:0]                sc_r;
  logic                             pend_r;
  logic                             pend_vld_r;
  logic                             any_dirty_r;
  logic [cqdd_pkg::CSN_W-1:0]       least_r;
  logic [cqdd_pkg::CSN_W-1:0]       most_r;

  logic [SLOT_AW-1:0]               wr_addr;
  logic                             wr_en;
  logic [SCNT_W-1:0]                scan_len;
  logic                             issue;
  logic [cqdd_pkg::WORD_W-1:0]      rd_word;
  logic [cqdd_pkg::WORD_W-1:0]      word;

  // Report write address, dropped when the slot lies beyond the store
  assign wr_addr = SLOT_AW'(ctl.rpt_slot);
  assign wr_en   = ctl.rpt_en && (int'(ctl.rpt_slot) < MAX_SLOTS);

  // Scan length is the smaller of the register and the store size
  assign scan_len = (int'(active_slots) >= MAX_SLOTS) ? SCNT_W'(MAX_SLOTS)
                                                      : SCNT_W'(active_slots);
  assign issue    = busy_r && (sc_r < scan_len);

  cqdd_ram #(
    .WIDTH (cqdd_pkg::WORD_W),
    .DEPTH (MAX_SLOTS),
    .AW    (SLOT_AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ctl.rpt_word),
    .re    (issue),
    .raddr (sc_r[SLOT_AW-1:0]),
    .rdata (rd_word)
  );

  // A slot never written reads as empty
  assign word = pend_vld_r ? rd_word : '0;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Scan sequencer: issue one read a cycle, fold each word in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sc_r        <= '0;
      pend_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      any_dirty_r <= 1'b0;
      least_r     <= '1;
      most_r      <= '0;
    end else if (ctl.scan_start) begin
      busy_r      <= 1'b1;
      sc_r        <= '0;
      pend_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      any_dirty_r <= 1'b0;
      least_r     <= '1;
      most_r      <= '0;
    end else if (busy_r) begin
      pend_r     <= issue;
      pend_vld_r <= issue && valid_r[sc_r[SLOT_AW-1:0]];
      if (issue) begin
        sc_r <= sc_r + SCNT_W'(1);
      end
      if (pend_r && (word != '0)) begin
        if (word[cqdd_pkg::WORD_W-1]) begin
          any_dirty_r <= 1'b1;
          if (word[cqdd_pkg::CSN_W-1:0] < least_r) begin
            least_r <= word[cqdd_pkg::CSN_W-1:0];
          end
        end else if (word[cqdd_pkg::CSN_W-1:0] > most_r) begin
          most_r <= word[cqdd_pkg::CSN_W-1:0];
        end
      end
      if (!issue && !pend_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Finished once every read is issued and folded
  assign stat.done    = busy_r && !issue && !pend_r;
  assign stat.durable = any_dirty_r ? least_r : most_r;

endmodule

// ===== rtl/core/commit_queue_durable_drain.sv =====
// ----------------------------------------------------------------------------
// commit_queue_durable_drain
// Ring queue of commit entries drained up to a global durable number.
// ----------------------------------------------------------------------------
// Usage:
//   One request enters on the in_ channel (valid/ready) and gives exactly one
//   result on the out_ channel (valid/ready). Requests are handled one at a
//   time by a controller around two RAMs: the entry queue (sequence number
//   and start time per entry) and the thread slot store.
//   A push or slot report passes through its own state before the response
//   state; an unknown command goes straight to the response state. A drain
//   scans the active slots (one slot RAM read a cycle), then pops entries
//   (one queue RAM read a cycle, the read of the next entry overlapping the
//   check of the current one) until the queue empties or an entry lies above
//   the durable number.
//   A finished result sits in an output register; the next request is
//   accepted while it waits, and is held at its response step until the
//   receiver takes the earlier result.
//   cfg_we/cfg_wdata write active_slots (reset 64) at any edge; write only
//   while idle.
//   Reset (rst_n low, synchronous) empties the queue, clears all slots,
//   the latency total and the durable number. No clearing pass is needed.
// ----------------------------------------------------------------------------
module commit_queue_durable_drain #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int MAX_SLOTS   = 64,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cqdd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cqdd_pkg::CMD_W-1:0]       in_command,
  input  logic [cqdd_pkg::CSN_W-1:0]       in_entry_csn,
  input  logic [cqdd_pkg::TIME_W-1:0]      in_start_time,
  input  logic                             in_want_insert,
  input  logic [cqdd_pkg::SLOT_IDX_W-1:0]  in_slot_index,
  input  logic                             in_slot_dirty,
  input  logic [cqdd_pkg::TIME_W-1:0]      in_end_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_flush_needed,
  output logic                             out_inserted,
  output logic [cqdd_pkg::CSN_W-1:0]       out_durable_csn,
  output logic [CNT_W-1:0]                 out_drained_count,
  output logic [cqdd_pkg::TIME_W-1:0]      out_latency_sum,
  output logic [CNT_W-1:0]                 out_occupancy
);

  localparam int QAW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENTRY_W   = cqdd_pkg::CSN_W + cqdd_pkg::TIME_W;
  // count * 5 >= depth * 4 rewritten as a threshold on count
  localparam int FLUSH_LVL = (4 * QUEUE_DEPTH + 4) / 5;

  cqdd_pkg::cqdd_state_t            state_r, state_nxt;

  // Latched request
  logic [cqdd_pkg::CSN_W-1:0]       csn_r;
  logic [cqdd_pkg::TIME_W-1:0]      t0_r;
  logic                             want_r;
  logic [cqdd_pkg::SLOT_IDX_W-1:0]  slot_r;
  logic                             dirty_r;
  logic [cqdd_pkg::TIME_W-1:0]      t1_r;

  // Queue and result state
  logic [QAW-1:0]                   head_r, head_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [cqdd_pkg::TIME_W-1:0]      lat_r, lat_nxt;
  logic [cqdd_pkg::CSN_W-1:0]       durable_r, durable_nxt;
  logic [CNT_W-1:0]                 drained_r, drained_nxt;
  logic                             flush_r, flush_nxt;
  logic                             ins_r, ins_nxt;
  logic [cqdd_pkg::CFG_W-1:0]       active_slots_r;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_load;

  logic                             in_acc;
  logic [QAW:0]                     tail_sum;
  logic [QAW-1:0]                   tail_idx;
  logic [QAW-1:0]                   head_inc;
  logic                             q_we;
  logic                             q_re;
  logic [QAW-1:0]                   q_raddr;
  logic [ENTRY_W-1:0]               q_rdata;
  logic [cqdd_pkg::CSN_W-1:0]       q_csn;
  logic [cqdd_pkg::TIME_W-1:0]      q_time;

  cqdd_pkg::cqdd_slot_ctl_t         slot_ctl;
  cqdd_pkg::cqdd_slot_stat_t        slot_stat;

  assign in_ready = (state_r == cqdd_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Tail slot and next head, wrapped for any depth
  assign tail_sum = (QAW+1)'(head_r) + (QAW+1)'(count_r);
  assign tail_idx = (int'(tail_sum) >= QUEUE_DEPTH) ? QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH))
                                                    : QAW'(tail_sum);
  assign head_inc = (int'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + QAW'(1);

  assign q_csn  = q_rdata[ENTRY_W-1:cqdd_pkg::TIME_W];
  assign q_time = q_rdata[cqdd_pkg::TIME_W-1:0];

  cqdd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (QAW)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_idx),
    .wdata ({csn_r, t0_r}),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Slot requests: start the scan as a drain is accepted
  assign slot_ctl.rpt_en     = (state_r == cqdd_pkg::ST_REPORT);
  assign slot_ctl.rpt_slot   = slot_r;
  assign slot_ctl.rpt_word   = {dirty_r, csn_r};
  assign slot_ctl.scan_start = in_acc && (in_command == cqdd_pkg::CMD_DRAIN);

  cqdd_slot_unit #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slot_unit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (slot_ctl),
    .active_slots (active_slots_r),
    .stat         (slot_stat)
  );

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      csn_r   <= in_entry_csn;
      t0_r    <= in_start_time;
      want_r  <= in_want_insert;
      slot_r  <= in_slot_index;
      dirty_r <= in_slot_dirty;
      t1_r    <= in_end_time;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r <= cqdd_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      active_slots_r <= cfg_wdata;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cqdd_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      lat_r       <= '0;
      durable_r   <= '0;
      drained_r   <= '0;
      flush_r     <= 1'b0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      lat_r       <= lat_nxt;
      durable_r   <= durable_nxt;
      drained_r   <= drained_nxt;
      flush_r     <= flush_nxt;
      ins_r       <= ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Controller: next state and queue updates
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    lat_nxt       = lat_r;
    durable_nxt   = durable_r;
    drained_nxt   = drained_r;
    flush_nxt     = flush_r;
    ins_nxt       = ins_r;
    q_we          = 1'b0;
    q_re          = 1'b0;
    q_raddr       = head_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      cqdd_pkg::ST_IDLE: begin
        if (in_acc) begin
          flush_nxt   = 1'b0;
          ins_nxt     = 1'b0;
          drained_nxt = '0;
          case (in_command)
            cqdd_pkg::CMD_PUSH:   state_nxt = cqdd_pkg::ST_PUSH;
            cqdd_pkg::CMD_REPORT: state_nxt = cqdd_pkg::ST_REPORT;
            cqdd_pkg::CMD_DRAIN:  state_nxt = cqdd_pkg::ST_SCAN;
            default:              state_nxt = cqdd_pkg::ST_RESP;
          endcase
        end
      end
      cqdd_pkg::ST_PUSH: begin
        flush_nxt = (int'(count_r) >= FLUSH_LVL);
        if (want_r && (int'(count_r) < QUEUE_DEPTH)) begin
          q_we      = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ins_nxt   = 1'b1;
        end
        state_nxt = cqdd_pkg::ST_RESP;
      end
      cqdd_pkg::ST_REPORT: begin
        state_nxt = cqdd_pkg::ST_RESP;
      end
      cqdd_pkg::ST_SCAN: begin
        if (slot_stat.done) begin
          durable_nxt = slot_stat.durable;
          state_nxt   = cqdd_pkg::ST_DRAIN_RD;
        end
      end
      cqdd_pkg::ST_DRAIN_RD: begin
        if (count_r == '0) begin
          state_nxt = cqdd_pkg::ST_RESP;
        end else begin
          q_re      = 1'b1;
          state_nxt = cqdd_pkg::ST_DRAIN_CHK;
        end
      end
      cqdd_pkg::ST_DRAIN_CHK: begin
        if (q_csn > durable_r) begin
          state_nxt = cqdd_pkg::ST_RESP;
        end else begin
          // Pop the head entry and fetch the next one, if any
          lat_nxt     = lat_r + (t1_r - q_time);
          head_nxt    = head_inc;
          count_nxt   = count_r - CNT_W'(1);
          drained_nxt = drained_r + CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = cqdd_pkg::ST_RESP;
          end else begin
            q_re    = 1'b1;
            q_raddr = head_inc;
          end
        end
      end
      cqdd_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cqdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cqdd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flush_needed  <= flush_r;
      out_inserted      <= ins_r;
      out_durable_csn   <= durable_r;
      out_drained_count <= drained_r;
      out_latency_sum   <= lat_r;
      out_occupancy     <= count_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks on the controller
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QUEUE_DEPTH)
    else $error("entry count beyond queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cqdd_pkg::ST_DRAIN_CHK) |-> (count_r != '0))
    else $error("drain check with empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    slot_stat.done |-> (state_r == cqdd_pkg::ST_SCAN))
    else $error("slot scan finished outside a drain");

  a_drain_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (drained_r != $past(drained_r)) && !$past(in_acc) |->
      ($past(state_r) == cqdd_pkg::ST_DRAIN_CHK))
    else $error("drained count moved outside a drain");

endmodule
